>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define VLMO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define VLMO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VLMO_ASSERT(lbl, clk, rst, prop, msg)
`define VLMO_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/vlmo_pkg.sv
`default_nettype none

package vlmo_pkg;

   localparam int LABEL_COUNT = 32;
   localparam int MAX_VOXELS  = 1048576;

   localparam int MASK_W      = 32;
   localparam int TABLE_DEPTH = 32;
   localparam int LABEL_W     = 5;
   localparam int LABEL_CNT_W = 7;
   localparam int RGB_W       = 24;
   localparam int OP_W        = 3;
   localparam int X_W         = 8;
   localparam int Y_W         = 8;
   localparam int Z_W         = 6;
   localparam int SX_W        = 9;
   localparam int SY_W        = 9;
   localparam int SZ_W        = 7;
   localparam int PART_W      = 15;
   localparam int LIN_W       = 25;
   localparam int ADDR_W      = $clog2(MAX_VOXELS);

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 32;

   localparam logic [SX_W-1:0] SIZE_X_RESET = SX_W'(128);
   localparam logic [SY_W-1:0] SIZE_Y_RESET = SY_W'(128);
   localparam logic [SZ_W-1:0] SIZE_Z_RESET = SZ_W'(64);
   localparam logic [MASK_W-1:0] ACTIVE_RESET = MASK_W'(1);

   // labels a query may report
   localparam int USED_LABELS = (LABEL_COUNT < MASK_W) ? LABEL_COUNT : MASK_W;
   localparam logic [MASK_W-1:0] LABEL_SPAN = MASK_W'((64'd1 << USED_LABELS) - 64'd1);

   typedef enum logic [OP_W-1:0] {
      OP_SET_BIT     = 3'd0,
      OP_CLEAR_BIT   = 3'd1,
      OP_CLEAR_LABEL = 3'd2,
      OP_ACTIVATE    = 3'd3,
      OP_DEACTIVATE  = 3'd4,
      OP_WRITE_COLOR = 3'd5,
      OP_QUERY       = 3'd6
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOC1,
      ST_LOC2,
      ST_DECIDE,
      ST_MODIFY,
      ST_SWEEP,
      ST_REPLY
   } state_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [RGB_W-1:0]   rgb_in;
      logic [LABEL_W-1:0] label;
      logic [Z_W-1:0]     z_coord;
      logic [Y_W-1:0]     y_coord;
      logic [X_W-1:0]     x_coord;
      op_type             opcode;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   typedef struct packed {
      logic [RGB_W-1:0]   rgb_out;
      logic [LABEL_W-1:0] hit_label;
      logic               hit;
      logic               status;
   } res_type;

   typedef struct packed {
      logic              in_range;
      logic [ADDR_W-1:0] idx;
   } loc_type;

endpackage

`default_nettype wire

>>> rtl/vlmo_locate.sv
`default_nettype none

// two-stage linear index: x + size_x * (y + size_y * z), with bound check
module vlmo_locate (
   input  wire logic                       clock,
   input  wire logic [vlmo_pkg::X_W-1:0]   x_coord,
   input  wire logic [vlmo_pkg::Y_W-1:0]   y_coord,
   input  wire logic [vlmo_pkg::Z_W-1:0]   z_coord,
   input  wire logic [vlmo_pkg::SX_W-1:0]  size_x,
   input  wire logic [vlmo_pkg::SY_W-1:0]  size_y,
   input  wire logic [vlmo_pkg::SZ_W-1:0]  size_z,
   output vlmo_pkg::loc_type                loc
);

   logic [vlmo_pkg::X_W-1:0]    x_s1_ff;
   logic [vlmo_pkg::PART_W-1:0] part_ff;
   logic                        coord_ok_ff;
   logic [vlmo_pkg::LIN_W-1:0]  lin;
   vlmo_pkg::loc_type           loc_ff;

   always_ff @(posedge clock) begin
      x_s1_ff     <= x_coord;
      part_ff     <= vlmo_pkg::PART_W'(y_coord) +
                     vlmo_pkg::PART_W'(size_y) * vlmo_pkg::PART_W'(z_coord);
      coord_ok_ff <= (vlmo_pkg::SX_W'(x_coord) < size_x) &&
                     (vlmo_pkg::SY_W'(y_coord) < size_y) &&
                     (vlmo_pkg::SZ_W'(z_coord) < size_z);
   end

   assign lin = vlmo_pkg::LIN_W'(x_s1_ff) +
                vlmo_pkg::LIN_W'(size_x) * vlmo_pkg::LIN_W'(part_ff);

   always_ff @(posedge clock) begin
      loc_ff.idx      <= lin[vlmo_pkg::ADDR_W-1:0];
      loc_ff.in_range <= coord_ok_ff && (lin < vlmo_pkg::LIN_W'(vlmo_pkg::MAX_VOXELS));
   end

   assign loc = loc_ff;

endmodule

`default_nettype wire

>>> rtl/voxel_label_mask_overlay_core.sv
// one item at a time; after its beat is taken an item passes the two multiply stages and the
// decide state, then a mask read for set, clear and query in range, before its result is registered
// next beat is taken once the result is in the output register, and no new item before then
// clear label walks every mask word, one a cycle
// synchronous reset zeroes the mask memory in a pass over all MAX_VOXELS (1048576) words,
// no item is taken meanwhile; sizes, active mask and colors reset at once
`default_nettype none

module voxel_label_mask_overlay_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // opcode, x_coord, y_coord, z_coord, label, rgb_in, zero pad
   input  wire logic [vlmo_pkg::REQ_DATA_W-1:0]     req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status, hit, hit_label, rgb_out, zero pad
   output      logic [vlmo_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [vlmo_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [vlmo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

`include "assert_macros.svh"

   vlmo_pkg::state_type               state_ff, state_in;
   logic [vlmo_pkg::ADDR_W-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [vlmo_pkg::MASK_W-1:0]       active_ff, active_in;
   vlmo_pkg::res_type                 res_ff, res_in;
   vlmo_pkg::res_type                 rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   vlmo_pkg::item_type                item_ff;
   logic [vlmo_pkg::SX_W-1:0]         size_x_ff;
   logic [vlmo_pkg::SY_W-1:0]         size_y_ff;
   logic [vlmo_pkg::SZ_W-1:0]         size_z_ff;
   logic [vlmo_pkg::RGB_W-1:0]        color_ff [vlmo_pkg::TABLE_DEPTH];
   logic                              color_we;

   logic [vlmo_pkg::MASK_W-1:0]       mask_mem [vlmo_pkg::MAX_VOXELS];
   logic [vlmo_pkg::MASK_W-1:0]       mem_q_ff;
   logic                              mem_we;
   logic [vlmo_pkg::ADDR_W-1:0]       mem_waddr;
   logic [vlmo_pkg::MASK_W-1:0]       mem_wdata;
   logic                              mem_re;
   logic [vlmo_pkg::ADDR_W-1:0]       mem_raddr;

   vlmo_pkg::loc_type                 loc;
   logic                              req_accept;
   logic                              label_ok;
   logic                              sweep_last;
   logic [vlmo_pkg::MASK_W-1:0]       label_bit;
   logic [vlmo_pkg::MASK_W-1:0]       hit_mask;
   logic                              hit;
   logic [vlmo_pkg::LABEL_W-1:0]      hit_lab;

   assign req_accept = req_tvalid && req_tready;
   assign label_ok   = vlmo_pkg::LABEL_CNT_W'(item_ff.label) <
                       vlmo_pkg::LABEL_CNT_W'(vlmo_pkg::LABEL_COUNT);
   assign label_bit  = vlmo_pkg::MASK_W'(1) << item_ff.label;
   assign sweep_last = sweep_addr_ff == vlmo_pkg::ADDR_W'(vlmo_pkg::MAX_VOXELS - 1);

   vlmo_locate u_locate (
      .clock   (clock),
      .x_coord (item_ff.x_coord),
      .y_coord (item_ff.y_coord),
      .z_coord (item_ff.z_coord),
      .size_x  (size_x_ff),
      .size_y  (size_y_ff),
      .size_z  (size_z_ff),
      .loc     (loc)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= vlmo_pkg::SIZE_X_RESET;
         size_y_ff <= vlmo_pkg::SIZE_Y_RESET;
         size_z_ff <= vlmo_pkg::SIZE_Z_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            vlmo_pkg::CSR_SIZE_X: size_x_ff <= csr_wdata;
            vlmo_pkg::CSR_SIZE_Y: size_y_ff <= csr_wdata;
            vlmo_pkg::CSR_SIZE_Z: size_z_ff <= csr_wdata[vlmo_pkg::SZ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= vlmo_pkg::item_type'(req_tdata[vlmo_pkg::ITEM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vlmo_pkg::TABLE_DEPTH; i++) begin
            color_ff[i] <= '0;
         end
      end else if (color_we) begin
         color_ff[item_ff.label] <= item_ff.rgb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mask_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mask_mem[mem_raddr];
      end
   end

   // lowest active label present in the word just read
   always_comb begin
      hit_mask = mem_q_ff & active_ff & vlmo_pkg::LABEL_SPAN;
      hit      = |hit_mask;
      hit_lab  = '0;
      for (int i = vlmo_pkg::MASK_W - 1; i >= 0; i--) begin
         if (hit_mask[i]) begin
            hit_lab = vlmo_pkg::LABEL_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      active_in     = active_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_tready    = 1'b0;
      color_we      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = sweep_addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = loc.idx;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         vlmo_pkg::ST_INIT: begin
            mem_we = 1'b1;
            if (sweep_last) begin
               sweep_addr_in = '0;
               state_in      = vlmo_pkg::ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         vlmo_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = vlmo_pkg::ST_LOC1;
            end
         end
         vlmo_pkg::ST_LOC1: state_in = vlmo_pkg::ST_LOC2;
         vlmo_pkg::ST_LOC2: state_in = vlmo_pkg::ST_DECIDE;
         vlmo_pkg::ST_DECIDE: begin
            res_in   = '0;
            state_in = vlmo_pkg::ST_REPLY;
            case (item_ff.opcode)
               vlmo_pkg::OP_SET_BIT, vlmo_pkg::OP_CLEAR_BIT, vlmo_pkg::OP_QUERY: begin
                  if (!loc.in_range) begin
                     res_in.status = 1'b1;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = vlmo_pkg::ST_MODIFY;
                  end
               end
               vlmo_pkg::OP_CLEAR_LABEL: begin
                  if (label_ok) begin
                     active_in     = active_ff & ~label_bit;
                     mem_re        = 1'b1;
                     mem_raddr     = '0;
                     sweep_addr_in = '0;
                     state_in      = vlmo_pkg::ST_SWEEP;
                  end
               end
               vlmo_pkg::OP_ACTIVATE: begin
                  if (label_ok) begin
                     active_in = active_ff | label_bit;
                  end
               end
               vlmo_pkg::OP_DEACTIVATE: begin
                  if (label_ok) begin
                     active_in = active_ff & ~label_bit;
                  end
               end
               vlmo_pkg::OP_WRITE_COLOR: color_we = label_ok;
               default: ;
            endcase
         end
         vlmo_pkg::ST_MODIFY: begin
            res_in   = '0;
            state_in = vlmo_pkg::ST_REPLY;
            if (item_ff.opcode == vlmo_pkg::OP_QUERY) begin
               res_in.hit       = hit;
               res_in.hit_label = hit_lab;
               res_in.rgb_out   = hit ? color_ff[hit_lab] : '0;
            end else if (label_ok) begin
               mem_we    = 1'b1;
               mem_waddr = loc.idx;
               mem_wdata = (item_ff.opcode == vlmo_pkg::OP_SET_BIT) ?
                           (mem_q_ff | label_bit) : (mem_q_ff & ~label_bit);
            end
         end
         vlmo_pkg::ST_SWEEP: begin
            // write back word n while word n+1 is read
            mem_we    = 1'b1;
            mem_wdata = mem_q_ff & ~label_bit;
            if (sweep_last) begin
               state_in = vlmo_pkg::ST_REPLY;
            end else begin
               mem_re        = 1'b1;
               mem_raddr     = sweep_addr_ff + 1'b1;
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         vlmo_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = vlmo_pkg::ST_IDLE;
            end
         end
         default: state_in = vlmo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vlmo_pkg::ST_INIT;
         sweep_addr_ff <= '0;
         active_ff     <= vlmo_pkg::ACTIVE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = vlmo_pkg::RSP_DATA_W'(rsp_ff);

   `VLMO_ASSERT(a_no_rw_same_word, clock, reset, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "mask memory read and write hit the same word")
   `VLMO_ASSERT(a_one_item_at_a_time, clock, reset, req_accept |=> !req_tready, "second beat taken while an item is in flight")
   `VLMO_ASSERT(a_sweep_writes_last_read, clock, reset, (state_ff == vlmo_pkg::ST_SWEEP) |-> (mem_waddr == $past(mem_raddr)), "label sweep wrote a word it did not read")
   `VLMO_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> (!rsp_tvalid && !req_tready), "handshake active right after reset")

endmodule

`default_nettype wire

>>> test/voxel_label_mask_overlay_core_tb.sv
`default_nettype none

module voxel_label_mask_overlay_core_tb;
   import vlmo_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   // a label clear and the mask clearing after reset each walk every mask word with no handshake
   localparam int unsigned QUIET_LIMIT = 4_500_000;
   localparam int unsigned POOL_SIZE = 8;
   localparam int RANDOM_PER_SETTING = 312;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predicted block state
   logic [MASK_W-1:0] voxel_masks [int unsigned];
   logic [MASK_W-1:0] active_labels;
   logic [RGB_W-1:0] label_colors [TABLE_DEPTH];
   logic [SX_W-1:0] vol_x;
   logic [SY_W-1:0] vol_y;
   logic [SZ_W-1:0] vol_z;

   res_type answer_q [$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic sending;

   logic [X_W-1:0] pool_x [POOL_SIZE];
   logic [Y_W-1:0] pool_y [POOL_SIZE];
   logic [Z_W-1:0] pool_z [POOL_SIZE];

   voxel_label_mask_overlay_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic res_type predict_answer(logic [OP_W-1:0] op, logic [X_W-1:0] x,
         logic [Y_W-1:0] y, logic [Z_W-1:0] z, logic [LABEL_W-1:0] lab, logic [RGB_W-1:0] rgb);
      res_type r;
      logic [63:0] lin;
      logic in_vol;
      logic lab_ok;
      logic [MASK_W-1:0] bit_sel;
      logic [MASK_W-1:0] word;
      int unsigned idx;
      r = '0;
      lin = 64'(x) + 64'(vol_x) * (64'(y) + 64'(vol_y) * 64'(z));
      in_vol = (x < vol_x) && (y < vol_y) && (z < vol_z) && (lin < 64'(MAX_VOXELS));
      idx = lin[31:0];
      lab_ok = int'(lab) < LABEL_COUNT;
      bit_sel = MASK_W'(1) << lab;
      word = voxel_masks.exists(idx) ? voxel_masks[idx] : '0;
      case (op)
         OP_SET_BIT, OP_CLEAR_BIT: begin
            if (!in_vol) begin
               r.status = 1'b1;
            end else if (lab_ok) begin
               voxel_masks[idx] = (op == OP_SET_BIT) ? (word | bit_sel) : (word & ~bit_sel);
            end
         end
         OP_CLEAR_LABEL: begin
            // every stored word, inside the current volume or not
            if (lab_ok) begin
               active_labels &= ~bit_sel;
               foreach (voxel_masks[k]) voxel_masks[k] &= ~bit_sel;
            end
         end
         OP_ACTIVATE: if (lab_ok) active_labels |= bit_sel;
         OP_DEACTIVATE: if (lab_ok) active_labels &= ~bit_sel;
         OP_WRITE_COLOR: if (lab_ok) label_colors[lab] = rgb;
         OP_QUERY: begin
            if (!in_vol) begin
               r.status = 1'b1;
            end else begin
               word &= active_labels;
               for (int i = 0; i < LABEL_COUNT && i < MASK_W; i++) begin
                  if (!r.hit && word[i]) begin
                     r.hit = 1'b1;
                     r.hit_label = LABEL_W'(i);
                     r.rgb_out = label_colors[i];
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_coord(int unsigned extent, int unsigned top);
      if (extent == 0) return $urandom_range(top);
      return $urandom_range((extent - 1 > top) ? top : extent - 1);
   endfunction

   task automatic log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic send_item(logic [OP_W-1:0] op, logic [X_W-1:0] x, logic [Y_W-1:0] y,
         logic [Z_W-1:0] z, logic [LABEL_W-1:0] lab, logic [RGB_W-1:0] rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         if (sending) begin
            req_tvalid <= 1'b0;
            sending = 1'b0;
         end
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      sending = 1'b1;
      req_tdata <= REQ_DATA_W'({rgb, lab, z, y, x, op});
      do @(posedge clock); while (!req_tready);
      answer_q.insert(answer_q.size(), predict_answer(op, x, y, z, lab, rgb));
   endtask

   task automatic drain();
      if (sending) begin
         req_tvalid <= 1'b0;
         sending = 1'b0;
      end
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_volume(int unsigned sx, int unsigned sy, int unsigned sz);
      drain();
      csr_we <= 1'b1;
      csr_addr <= CSR_SIZE_X;
      csr_wdata <= CSR_DATA_W'(sx);
      @(posedge clock);
      csr_addr <= CSR_SIZE_Y;
      csr_wdata <= CSR_DATA_W'(sy);
      @(posedge clock);
      csr_addr <= CSR_SIZE_Z;
      csr_wdata <= CSR_DATA_W'(sz);
      @(posedge clock);
      csr_we <= 1'b0;
      vol_x = SX_W'(sx);
      vol_y = SY_W'(sy);
      vol_z = SZ_W'(sz);
      // a few voxels that get hit over and over so queries find labels
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_x[i] = X_W'(pick_coord(vol_x, 255));
         pool_y[i] = Y_W'(pick_coord(vol_y, 255));
         pool_z[i] = Z_W'(pick_coord(vol_z, 63));
      end
   endtask

   task automatic send_random_item();
      logic [OP_W-1:0] op;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic [Z_W-1:0] z;
      logic [LABEL_W-1:0] lab;
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(99);
      // label clears cost a full sweep, so only the directed part uses them
      if (pick < 30) op = OP_SET_BIT;
      else if (pick < 40) op = OP_CLEAR_BIT;
      else if (pick < 72) op = OP_QUERY;
      else if (pick < 82) op = OP_ACTIVATE;
      else if (pick < 88) op = OP_DEACTIVATE;
      else if (pick < 97) op = OP_WRITE_COLOR;
      else op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 70) begin
         k = $urandom_range(POOL_SIZE - 1);
         x = pool_x[k];
         y = pool_y[k];
         z = pool_z[k];
      end else if (pick < 90) begin
         x = X_W'(pick_coord(vol_x, 255));
         y = Y_W'(pick_coord(vol_y, 255));
         z = Z_W'(pick_coord(vol_z, 63));
      end else begin
         x = X_W'($urandom);
         y = Y_W'($urandom);
         z = Z_W'($urandom);
      end
      lab = ($urandom_range(99) < 75) ? LABEL_W'($urandom_range(7)) : LABEL_W'($urandom);
      send_item(op, x, y, z, lab, RGB_W'($urandom));
   endtask

   task automatic test_label_ops();
      send_item(OP_WRITE_COLOR, 8'd0, 8'd0, 6'd0, 5'd0, 24'hFFFFFF);
      send_item(OP_WRITE_COLOR, 8'd0, 8'd0, 6'd0, 5'd31, 24'h5A5A5A);
      send_item(OP_SET_BIT, 8'd127, 8'd127, 6'd63, 5'd0, 24'h0);
      send_item(OP_QUERY, 8'd127, 8'd127, 6'd63, 5'd0, 24'h0);
      send_item(OP_SET_BIT, 8'd0, 8'd0, 6'd0, 5'd31, 24'h0);
      // label 31 is still inactive
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_ACTIVATE, 8'd0, 8'd0, 6'd0, 5'd31, 24'h0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_SET_BIT, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_DEACTIVATE, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
      send_item(OP_CLEAR_BIT, 8'd0, 8'd0, 6'd0, 5'd31, 24'h0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
   endtask

   task automatic test_bounds();
      send_item(OP_SET_BIT, 8'd128, 8'd0, 6'd0, 5'd1, 24'h0);
      send_item(OP_QUERY, 8'd255, 8'd255, 6'd63, 5'd0, 24'h0);
      send_item(OP_UNUSED, 8'hFF, 8'hFF, 6'h3F, 5'h1F, 24'hFFFFFF);
      // full extents overflow the voxel store past z = 15
      set_volume(256, 256, 64);
      send_item(OP_QUERY, 8'd255, 8'd255, 6'd15, 5'd0, 24'h0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd16, 5'd0, 24'h0);
      set_volume(0, 0, 0);
      send_item(OP_QUERY, 8'd0, 8'd0, 6'd0, 5'd0, 24'h0);
   endtask

   task automatic test_clear_label();
      set_volume(128, 128, 64);
      send_item(OP_SET_BIT, 8'd127, 8'd127, 6'd63, 5'd7, 24'h0);
      send_item(OP_SET_BIT, 8'd1, 8'd2, 6'd0, 5'd7, 24'h0);
      send_item(OP_ACTIVATE, 8'd0, 8'd0, 6'd0, 5'd7, 24'h0);
      // shrink so the far corner lies outside the volume during the sweep
      set_volume(128, 128, 1);
      send_item(OP_CLEAR_LABEL, 8'd0, 8'd0, 6'd0, 5'd7, 24'h0);
      set_volume(128, 128, 64);
      send_item(OP_SET_BIT, 8'd5, 8'd5, 6'd5, 5'd7, 24'h0);
      send_item(OP_QUERY, 8'd5, 8'd5, 6'd5, 5'd0, 24'h0);
      send_item(OP_ACTIVATE, 8'd0, 8'd0, 6'd0, 5'd7, 24'h0);
      send_item(OP_QUERY, 8'd127, 8'd127, 6'd63, 5'd0, 24'h0);
      send_item(OP_QUERY, 8'd5, 8'd5, 6'd5, 5'd0, 24'h0);
   endtask

   task automatic test_random(int unsigned s_pct, int unsigned r_pct, int first_setting);
      for (int s = first_setting; s < first_setting + 2; s++) begin
         case (s)
            0: set_volume(256, 256, 64);
            1: set_volume(1, 1, 1);
            2: set_volume($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 64));
            3: set_volume(511, 511, 127);
            4: set_volume($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8));
            default: set_volume(128, 128, 64);
         endcase
         send_idle_pct = s_pct;
         recv_idle_pct = r_pct;
         repeat (RANDOM_PER_SETTING) send_random_item();
      end
   endtask

   always @(posedge clock) begin
      res_type got;
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(res_type)-1:0];
         if (answer_q.size() == 0) begin
            log_mismatch($sformatf("unexpected beat: status %0d hit %0d label %0d rgb %06h",
               got.status, got.hit, got.hit_label, got.rgb_out));
         end else begin
            want = answer_q.pop_front();
            if (got !== want)
               log_mismatch($sformatf({"mismatch: expected status %0d hit %0d label %0d ",
                  "rgb %06h, got status %0d hit %0d label %0d rgb %06h"},
                  want.status, want.hit, want.hit_label, want.rgb_out,
                  got.status, got.hit, got.hit_label, got.rgb_out));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_SIZE_X;
      csr_wdata = '0;
      sending = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 21;
      recv_idle_pct = 86;
      active_labels = ACTIVE_RESET;
      foreach (label_colors[i]) label_colors[i] = '0;
      vol_x = SIZE_X_RESET;
      vol_y = SIZE_Y_RESET;
      vol_z = SIZE_Z_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // mask memory is cleared before the first beat is taken
      do @(posedge clock); while (!req_tready);

      test_label_ops();
      test_bounds();
      test_clear_label();
      test_random(21, 86, 0);
      test_random(86, 21, 2);
      test_random(0, 0, 4);

      drain();
      repeat (10) @(posedge clock);
      if (answer_q.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", answer_q.size()));
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
